// File: hdl/rllup_pkg.sv
// ----------------------------------------------------------------------------
// rllup_pkg
// Shared types and constants of the rate-limited lag unicycle plant.
// ----------------------------------------------------------------------------
package rllup_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TURN_LIMIT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LAG_COEF    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_START_HEAD  = 3'd7;

    localparam logic [31:0] SIN_A   = 32'd1686629713;
    localparam logic [31:0] SIN_B   = 32'd688904866;
    localparam logic [31:0] SIN_C   = 32'd76016977;
    localparam logic [31:0] QUARTER = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] speed_command;
        logic signed [31:0] turn_command;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [31:0] heading;
        logic signed [31:0] real_speed;
        logic signed [31:0] real_turn_rate;
    } t_pose;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/rllup_if.sv
// ----------------------------------------------------------------------------
// rllup_cmd_if / rllup_pose_if / rllup_cfg_if
// Valid/ready channels of the plant model.
// ----------------------------------------------------------------------------
interface rllup_cmd_if import rllup_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rllup_pose_if import rllup_pkg::*; ();
    logic  valid;
    logic  ready;
    t_pose data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rllup_cfg_if import rllup_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/rllup_mul.sv
// ----------------------------------------------------------------------------
// rllup_mul
// Shared registered 33x33 signed multiplier used by the sequencer.
// ----------------------------------------------------------------------------
module rllup_mul import rllup_pkg::*; (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: hdl/rate_limited_lag_unicycle_plant_top.sv
// ----------------------------------------------------------------------------
// rate_limited_lag_unicycle_plant_top
// Slew limit, transport delay, first-order lag and unicycle pose update,
// one tick per command transaction, on one shared multiplier.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// i_cmd    | in  | speed_command, turn_command
// o_pose   | out | position_x, position_y, heading, real_speed, real_turn_rate
// i_cfg    | in  | register index, write data
//
// From acceptance to result of a command, the sequencer walks
// one multiplier through 14 products (lag, two sine polynomials, pose).
// A new command is taken only once the sequencer is back in its idle state.
// A command is taken while the previous result still waits; the sequencer
// holds in its last step until the result register is free again.
// Reset (synchronous, active low) is immediate; the delay line needs no
// clearing pass, a fill count masks unwritten entries.
// ----------------------------------------------------------------------------
module rate_limited_lag_unicycle_plant_top import rllup_pkg::*; #(
    parameter int unsigned MAX_DELAY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rllup_cmd_if.sink       i_cmd,
    rllup_pose_if.source    o_pose,
    rllup_cfg_if.sink       i_cfg
);
    localparam int unsigned AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int unsigned CW = $clog2(MAX_DELAY + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;  // memory read data used
    localparam logic [4:0] S_LAG0 = 5'd2;
    localparam logic [4:0] S_LAG1 = 5'd3;
    localparam logic [4:0] S_LAG2 = 5'd4;
    localparam logic [4:0] S_LAG3 = 5'd5;
    localparam logic [4:0] S_LAGW = 5'd6;
    localparam logic [4:0] S_SIN  = 5'd7;  // polynomial steps, uses r_sub
    localparam logic [4:0] S_PX   = 5'd8;
    localparam logic [4:0] S_PY   = 5'd9;
    localparam logic [4:0] S_PW   = 5'd10;
    localparam logic [4:0] S_FIN  = 5'd11;
    localparam logic [4:0] S_OUT  = 5'd12;

    // configuration
    logic [30:0] r_spd_lim, r_trn_lim;
    logic [6:0]  r_delay;
    logic [15:0] r_lag_a, r_gain;

    // state
    logic signed [31:0] r_slew_v, r_slew_w, r_lag_v, r_lag_w;
    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_hd;
    logic [AW-1:0]      r_wi;
    logic [CW-1:0]      r_fill;

    logic [63:0] r_mem [MAX_DELAY];
    logic [63:0] r_rd;

    logic [4:0]  r_st;
    logic [3:0]  r_sub;
    logic        r_use_now, r_rd_zero;
    logic signed [31:0] r_vin, r_win;
    logic signed [63:0] r_acc;
    logic [31:0] r_z, r_z2, r_t;
    logic        r_neg;
    logic signed [31:0] r_cos, r_sin;
    logic        r_ovalid;
    t_pose       r_out;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;

    rllup_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    // slew
    logic signed [32:0] w_dv, w_dw, w_cv, w_cw;
    assign w_dv = 33'(i_cmd.data.speed_command) - 33'(r_slew_v);
    assign w_dw = 33'(i_cmd.data.turn_command) - 33'(r_slew_w);
    always_comb begin
        w_cv = w_dv;
        if (w_dv > $signed({2'b00, r_spd_lim})) w_cv = $signed({2'b00, r_spd_lim});
        else if (w_dv < -$signed({2'b00, r_spd_lim})) w_cv = -$signed({2'b00, r_spd_lim});
        w_cw = w_dw;
        if (w_dw > $signed({2'b00, r_trn_lim})) w_cw = $signed({2'b00, r_trn_lim});
        else if (w_dw < -$signed({2'b00, r_trn_lim})) w_cw = -$signed({2'b00, r_trn_lim});
    end

    logic [CW-1:0] w_d;
    assign w_d = (32'(r_delay) > 32'(MAX_DELAY)) ? CW'(MAX_DELAY) : CW'(r_delay);
    logic [AW-1:0] w_ri;
    assign w_ri = (32'(r_wi) >= 32'(w_d)) ? AW'(32'(r_wi) - 32'(w_d))
                                          : AW'(32'(r_wi) + 32'(MAX_DELAY) - 32'(w_d));

    logic w_acc_in;
    logic w_fire;
    assign w_acc_in = i_cmd.valid && i_cmd.ready;
    assign w_fire = (r_st == S_OUT) && (!r_ovalid || o_pose.ready);
    assign i_cmd.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_pose.valid = r_ovalid;
    assign o_pose.data = r_out;

    // sine step schedule in r_sub: 0..3 for sin(h), 5..8 for cos
    // step k of a polynomial: 0 z*z, 1 C*z2, 2 (B-t)*z2, 3 (A-t)*z
    logic [31:0] w_ang, w_zr;
    logic [2:0]  w_k;
    assign w_ang = (r_sub < 4'd5) ? r_hd : r_hd + QUARTER;
    assign w_k = (r_sub < 4'd5) ? 3'(r_sub) : 3'(r_sub - 4'd5);
    assign w_zr = w_ang[30] ? QUARTER - {2'b00, w_ang[29:0]} : {2'b00, w_ang[29:0]};

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            S_LAG0: begin w_ma = {17'd0, r_lag_a}; w_mb = 33'(r_lag_v); end
            S_LAG1: begin w_ma = {17'd0, r_gain};  w_mb = 33'(r_vin);   end
            S_LAG2: begin w_ma = {17'd0, r_lag_a}; w_mb = 33'(r_lag_w); end
            S_LAG3: begin w_ma = {17'd0, r_gain};  w_mb = 33'(r_win);   end
            S_SIN: begin
                unique case (w_k)
                    3'd0: begin w_ma = {1'b0, w_zr}; w_mb = {1'b0, w_zr}; end
                    3'd1: begin w_ma = {1'b0, SIN_C}; w_mb = {1'b0, r_z2}; end
                    3'd2: begin w_ma = {1'b0, SIN_B - r_t}; w_mb = {1'b0, r_z2}; end
                    3'd3: begin w_ma = {1'b0, SIN_A - r_t}; w_mb = {1'b0, r_z}; end
                    default: ;
                endcase
            end
            S_PX: begin w_ma = 33'(r_lag_v); w_mb = 33'(r_cos); end
            // keep the sine product alive while the result register is busy
            S_PY, S_OUT: begin w_ma = 33'(r_lag_v); w_mb = 33'(r_sin); end
            default: ;
        endcase
    end

    // floor(v/2^16) after +2^15, saturated
    logic signed [63:0] w_lagr;
    assign w_lagr = (r_acc + 64'sd32768) >>> 16;
    logic signed [63:0] w_pp;
    assign w_pp = 64'(w_mp >>> 30);

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_rd <= r_mem[w_ri];
            r_mem[r_wi] <= {32'(r_slew_w + w_cw[31:0]), 32'(r_slew_v + w_cv[31:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_lim <= 31'd629;
            r_trn_lim <= 31'd68359;
            r_delay   <= 7'd40;
            r_lag_a   <= 16'd64063;
            r_gain    <= 16'd1311;
            r_px <= '0; r_py <= '0; r_hd <= '0;
            r_slew_v <= '0; r_slew_w <= '0; r_lag_v <= '0; r_lag_w <= '0;
            r_wi <= '0; r_fill <= '0;
            r_st <= S_IDLE; r_sub <= '0; r_ovalid <= 1'b0;
        end else begin
            if (w_fire) r_ovalid <= 1'b1;
            else if (o_pose.valid && o_pose.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_SPEED_LIMIT: r_spd_lim <= i_cfg.data.data[30:0];
                    REG_TURN_LIMIT:  r_trn_lim <= i_cfg.data.data[30:0];
                    REG_DELAY:       r_delay   <= i_cfg.data.data[6:0];
                    REG_LAG_COEF:    r_lag_a   <= i_cfg.data.data[15:0];
                    REG_DRIVE_GAIN:  r_gain    <= i_cfg.data.data[15:0];
                    REG_START_X:     r_px <= i_cfg.data.data;
                    REG_START_Y:     r_py <= i_cfg.data.data;
                    REG_START_HEAD:  r_hd <= i_cfg.data.data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (w_acc_in) begin
                    r_slew_v <= r_slew_v + w_cv[31:0];
                    r_slew_w <= r_slew_w + w_cw[31:0];
                    r_vin <= r_slew_v + w_cv[31:0];
                    r_win <= r_slew_w + w_cw[31:0];
                    r_use_now <= (w_d == '0);
                    r_rd_zero <= (r_fill < w_d);
                    r_wi <= (32'(r_wi) == 32'(MAX_DELAY) - 32'd1) ? '0 : r_wi + 1'b1;
                    if (r_fill != CW'(MAX_DELAY)) r_fill <= r_fill + 1'b1;
                    r_st <= S_RD;
                end
                S_RD: begin
                    if (!r_use_now) begin
                        r_vin <= r_rd_zero ? '0 : $signed(r_rd[31:0]);
                        r_win <= r_rd_zero ? '0 : $signed(r_rd[63:32]);
                    end
                    r_st <= S_LAG0;
                end
                S_LAG0: r_st <= S_LAG1;
                S_LAG1: begin r_acc <= 64'(w_mp); r_st <= S_LAG2; end
                S_LAG2: begin r_acc <= r_acc + 64'(w_mp); r_st <= S_LAG3; end
                S_LAG3: begin
                    r_lag_v <= sat32(w_lagr);
                    r_acc <= 64'(w_mp);
                    r_st <= S_LAGW;
                end
                S_LAGW: begin r_acc <= r_acc + 64'(w_mp); r_st <= S_FIN; end
                S_FIN: begin
                    r_lag_w <= sat32(w_lagr);
                    r_sub <= '0;
                    r_st <= S_SIN;
                end
                S_SIN: begin
                    // each step issues a product here; the registered result is taken
                    // in S_PW, which loads r_z2, r_t or the sine or cosine result
                    unique case (w_k)
                        3'd0: begin r_z <= w_zr; r_neg <= w_ang[31]; end
                        default: ;
                    endcase
                    r_st <= S_PW;
                end
                S_PW: begin
                    unique case (w_k)
                        3'd0: r_z2 <= w_mp[61:30];
                        3'd1, 3'd2: r_t <= w_mp[61:30];
                        3'd3: begin
                            if (r_sub < 4'd5)
                                r_sin <= r_neg ? -$signed(w_mp[61:30]) : $signed(w_mp[61:30]);
                            else
                                r_cos <= r_neg ? -$signed(w_mp[61:30]) : $signed(w_mp[61:30]);
                        end
                        default: ;
                    endcase
                    if (w_k == 3'd3) begin
                        if (r_sub < 4'd5) begin r_sub <= 4'd5; r_st <= S_SIN; end
                        else r_st <= S_PX;
                    end else begin
                        r_sub <= r_sub + 1'b1;
                        r_st <= S_SIN;
                    end
                end
                S_PX: r_st <= S_PY;
                S_PY: begin r_px <= sat32(64'(r_px) + w_pp); r_st <= S_OUT; end
                // hold here until the result register can take the pose
                S_OUT: if (w_fire) begin
                    r_py <= sat32(64'(r_py) + w_pp);
                    r_out.position_x <= r_px;
                    r_out.position_y <= sat32(64'(r_py) + w_pp);
                    r_out.heading <= r_hd + r_lag_w;
                    r_out.real_speed <= r_lag_v;
                    r_out.real_turn_rate <= r_lag_w;
                    r_hd <= r_hd + r_lag_w;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/rllup_checker.sv
// ----------------------------------------------------------------------------
// rllup_checker
// Port-level checks of the plant model, bound to the top level.
// ----------------------------------------------------------------------------
module rllup_checker import rllup_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input t_pose out_data
);
    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result valid after reset");
    // a new result never appears right after a command
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");
    // not ready right after accepting
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("result dropped");
endmodule

bind rate_limited_lag_unicycle_plant_top rllup_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_cmd.valid), .in_ready(i_cmd.ready),
    .out_valid(o_pose.valid), .out_ready(o_pose.ready), .out_data(o_pose.data)
);
